// ===== hw/rtl/dmrle_pkg.sv =====
// Shared constants and controller/datapath types for the byte run-length decoder.
package dmrle_pkg;

  localparam int unsigned SIZE_BITS  = 24;
  localparam int unsigned CODE_W     = 8;
  localparam int unsigned COUNT_W    = 6;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = SIZE_BITS;

  localparam logic [CODE_W-1:0] MARK_MASK  = 8'hC0;
  localparam logic [CODE_W-1:0] COUNT_MASK = 8'h3F;
  localparam logic [CODE_W-1:0] PCX_MARK   = 8'hC0;
  localparam logic [CODE_W-1:0] RLE8_MARK  = 8'h40;

  localparam logic [CFG_IDX_W-1:0] REG_RUN_MODE   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_SIZE = 1'd1;

  typedef struct packed {
    logic take;      // an input byte is transferred this cycle
    logic set_mark;  // the byte is a run marker
    logic load_run;  // the byte is a run value and the run starts
    logic emit_lit;  // the byte goes out as a literal
    logic emit_run;  // one byte of the current run goes out
  } dmrle_cmd_t;

  typedef struct packed {
    logic pending;   // the byte on the input is a run value
    logic marker;    // the byte on the input matches the marker of the mode
    logic run_ok;    // the pending run has a count and room in the image
    logic lit_ok;    // a literal on the input fits in the image
    logic out_free;  // the output register can be loaded this cycle
    logic run_last;  // the next run byte ends the run
  } dmrle_stat_t;

endpackage

// ===== hw/rtl/dmrle_in_if.sv =====
// Input channel carrying encoded bytes.
interface dmrle_in_if;
  logic                          valid;
  logic                          ready;
  logic [dmrle_pkg::CODE_W-1:0]  code_byte;
  logic                          start_image;

  modport source (output valid, output code_byte, output start_image, input ready);
  modport sink   (input valid, input code_byte, input start_image, output ready);
endinterface

// ===== hw/rtl/dmrle_out_if.sv =====
// Output channel carrying decoded pixel bytes.
interface dmrle_out_if;
  logic                          valid;
  logic                          ready;
  logic [dmrle_pkg::CODE_W-1:0]  pixel_byte;
  logic                          last_of_item;
  logic                          image_done;

  modport source (output valid, output pixel_byte, output last_of_item,
                  output image_done, input ready);
  modport sink   (input valid, input pixel_byte, input last_of_item,
                  input image_done, output ready);
endinterface

// ===== hw/rtl/dmrle_ctrl.sv =====
// Controller state machine: sequences input transfers and run emission.
module dmrle_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  dmrle_pkg::dmrle_stat_t stat_i,
  output dmrle_pkg::dmrle_cmd_t  cmd_o
);
  import dmrle_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic state_q, state_d;

  assign in_ready_o = (state_q == ST_IDLE) && stat_i.out_free;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i && in_ready_o) begin
          cmd_o.take = 1'b1;
          priority if (stat_i.pending) begin
            // A run with no count or no room in the image is simply dropped.
            if (stat_i.run_ok) begin
              cmd_o.load_run = 1'b1;
              state_d        = ST_RUN;
            end
          end else if (stat_i.marker) begin
            cmd_o.set_mark = 1'b1;
          end else if (stat_i.lit_ok) begin
            cmd_o.emit_lit = 1'b1;
          end
        end
      end
      ST_RUN: begin
        if (stat_i.out_free) begin
          cmd_o.emit_run = 1'b1;
          if (stat_i.run_last) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  a_no_take_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN) |-> !in_ready_o)
    else $error("input transfer offered while a run is being emitted");

  a_load_enters_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_run |=> (state_q == ST_RUN))
    else $error("run loaded without entering the run state");

endmodule

// ===== hw/rtl/dmrle_dp.sv =====
// Datapath: configuration, decode state, byte counter and output register.
module dmrle_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [dmrle_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [dmrle_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic [dmrle_pkg::CODE_W-1:0]        code_byte_i,
  input  logic                                start_image_i,
  input  dmrle_pkg::dmrle_cmd_t               cmd_i,
  output dmrle_pkg::dmrle_stat_t              stat_o,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [dmrle_pkg::CODE_W-1:0]        pixel_byte_o,
  output logic                                last_of_item_o,
  output logic                                image_done_o
);
  import dmrle_pkg::*;

  logic                 run_mode_q;
  logic [SIZE_BITS-1:0] image_size_q;

  logic                 pend_q, pend_d;
  logic [COUNT_W-1:0]   count_q, count_d;
  logic [COUNT_W-1:0]   remain_q, remain_d;
  logic [CODE_W-1:0]    value_q, value_d;
  logic [SIZE_BITS-1:0] bytes_q, bytes_d;
  logic                 full_q, full_d;

  logic                 out_valid_q, out_valid_d;
  logic [CODE_W-1:0]    pix_q, pix_d;
  logic                 last_q, last_d;
  logic                 done_q, done_d;

  logic [SIZE_BITS-1:0] bytes_b, bytes_cur, bytes_inc;
  logic                 full_b, pend_b, can_emit_b, emit, hit_limit;
  logic [CODE_W-1:0]    marker;

  // A start flag clears the image state before its own byte is decoded.
  assign bytes_b    = start_image_i ? '0 : bytes_q;
  assign full_b     = start_image_i ? 1'b0 : full_q;
  assign pend_b     = start_image_i ? 1'b0 : pend_q;
  assign can_emit_b = !full_b && (bytes_b < image_size_q);
  assign marker     = run_mode_q ? RLE8_MARK : PCX_MARK;

  assign emit      = cmd_i.emit_lit || cmd_i.emit_run;
  assign bytes_cur = cmd_i.take ? bytes_b : bytes_q;
  assign bytes_inc = bytes_cur + SIZE_BITS'(1);
  assign hit_limit = (bytes_inc == image_size_q);

  always_comb begin
    stat_o.pending  = pend_b;
    stat_o.marker   = ((code_byte_i & MARK_MASK) == marker);
    stat_o.run_ok   = (count_q != '0) && can_emit_b;
    stat_o.lit_ok   = can_emit_b;
    stat_o.out_free = !out_valid_q || out_ready_i;
    stat_o.run_last = (remain_q == COUNT_W'(1)) || hit_limit;
  end

  always_comb begin
    pend_d      = pend_q;
    count_d     = count_q;
    remain_d    = remain_q;
    value_d     = value_q;
    bytes_d     = bytes_q;
    full_d      = full_q;
    pix_d       = pix_q;
    last_d      = last_q;
    done_d      = done_q;
    out_valid_d = out_ready_i ? 1'b0 : out_valid_q;

    if (cmd_i.take) begin
      bytes_d = bytes_b;
      full_d  = full_b;
      pend_d  = cmd_i.set_mark;
    end
    if (cmd_i.set_mark) begin
      count_d = COUNT_W'(code_byte_i & COUNT_MASK);
    end
    if (cmd_i.load_run) begin
      value_d  = code_byte_i;
      remain_d = count_q;
    end
    if (emit) begin
      bytes_d     = bytes_inc;
      full_d      = (cmd_i.take ? full_b : full_q) || hit_limit;
      out_valid_d = 1'b1;
      pix_d       = cmd_i.emit_lit ? code_byte_i : value_q;
      last_d      = cmd_i.emit_lit || (remain_q == COUNT_W'(1)) || hit_limit;
      done_d      = hit_limit;
    end
    if (cmd_i.emit_run) begin
      remain_d = remain_q - COUNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_mode_q   <= 1'b0;
      image_size_q <= '0;
      pend_q       <= 1'b0;
      count_q      <= '0;
      remain_q     <= '0;
      bytes_q      <= '0;
      full_q       <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_RUN_MODE:   run_mode_q   <= cfg_data_i[0];
          REG_IMAGE_SIZE: image_size_q <= cfg_data_i;
          default: ;
        endcase
      end
      pend_q      <= pend_d;
      count_q     <= count_d;
      remain_q    <= remain_d;
      bytes_q     <= bytes_d;
      full_q      <= full_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
    pix_q   <= pix_d;
    last_q  <= last_d;
    done_q  <= done_d;
  end

  assign out_valid_o    = out_valid_q;
  assign pixel_byte_o   = pix_q;
  assign last_of_item_o = last_q;
  assign image_done_o   = done_q;

  a_run_within_image: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit_run |-> (!full_q && (bytes_q < image_size_q) && (remain_q != '0)))
    else $error("run byte emitted beyond the image or after the run ended");

  a_done_sets_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && hit_limit) |=> (full_q && out_valid_q && done_q && last_q))
    else $error("filling byte did not mark the image full");

  a_single_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd_i.emit_lit && cmd_i.emit_run) && !(emit && !stat_o.out_free))
    else $error("output register loaded twice or while occupied");

endmodule

// ===== hw/rtl/dual_mode_byte_rle_decoder.sv =====
// Top level of the dual-mode byte run-length decoder.
// Encoded bytes arrive one per transfer and decoded pixel bytes leave through a
// single output register. A literal byte is taken and loaded into the output
// register in the same cycle, so literals flow at one per cycle while the output
// side keeps taking them; a marker byte emits nothing; a run value byte is taken
// and then holds the input while the run is emitted one byte a cycle whenever the
// output register is free, until its count is spent or the image is full. The
// input is held whenever the output register is occupied and not being taken, and
// bytes that would overflow the configured image size are dropped. Write the
// mode and image size only while the block is idle.
module dual_mode_byte_rle_decoder (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [dmrle_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [dmrle_pkg::CFG_DATA_W-1:0] cfg_data_i,
  dmrle_in_if.sink                         byte_in_i,
  dmrle_out_if.source                      pix_out_o
);
  import dmrle_pkg::*;

  dmrle_cmd_t  cmd;
  dmrle_stat_t stat;

  dmrle_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (byte_in_i.valid),
    .in_ready_o (byte_in_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  dmrle_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .code_byte_i    (byte_in_i.code_byte),
    .start_image_i  (byte_in_i.start_image),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .out_valid_o    (pix_out_o.valid),
    .out_ready_i    (pix_out_o.ready),
    .pixel_byte_o   (pix_out_o.pixel_byte),
    .last_of_item_o (pix_out_o.last_of_item),
    .image_done_o   (pix_out_o.image_done)
  );

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for the dual-mode byte run-length decoder.
`timescale 1ns / 100ps

module tb;
  import dmrle_pkg::*;

  localparam int unsigned DRAIN_CYCLES = 80;    // longest run plus the output register
  localparam int unsigned HOLD_CYCLES  = 150;
  localparam int unsigned STALL_LIMIT  = 2000;
  localparam int unsigned PHASES       = 6;
  localparam int unsigned PHASE_ITEMS  = 41;
  localparam int unsigned PLAN_LEN     = 31;

  localparam logic [CFG_DATA_W-1:0] MODE_PCX  = 24'd0;
  localparam logic [CFG_DATA_W-1:0] MODE_RLE8 = 24'd1;
  localparam logic [CFG_DATA_W-1:0] SIZE_MAX  = 24'hFFFFFF;

  typedef enum logic [1:0] {ROW_BYTE, ROW_MODE, ROW_SIZE} row_kind_e;

  typedef struct {
    row_kind_e             kind;
    logic [CFG_DATA_W-1:0] val;    // code byte in the low bits, or register value
    logic                  start;
    int                    n;      // typed number of copies of the code byte, -1: predicted
    logic                  dn;     // typed done flag on the final copy
  } row_t;

  typedef struct {
    logic [CODE_W-1:0] px;
    logic              last;
    logic              done;
  } pix_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  dmrle_in_if  code_if ();
  dmrle_out_if pix_if ();

  dual_mode_byte_rle_decoder DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .byte_in_i  (code_if),
    .pix_out_o  (pix_if)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Decoder state as the predictor sees it.
  logic                  p_mode;
  logic [SIZE_BITS-1:0]  p_size;
  logic                  run_armed;
  logic [COUNT_W-1:0]    run_len;
  logic [SIZE_BITS-1:0]  emitted;
  logic                  img_full;

  pix_t new_pixels[$];
  pix_t due_pixels[$];

  logic        in_took = 1'b0;
  logic        row_typed = 1'b0;
  int          row_n;
  logic        row_dn;
  logic        steady = 1'b0;
  logic        hold_req = 1'b0;
  int unsigned hold_left = 0;
  int unsigned stall_cycles = 0;
  int unsigned errors = 0;
  int unsigned bytes_in = 0;
  int unsigned pixels_out = 0;
  int unsigned images_done = 0;
  int unsigned reg_writes = 0;

  function automatic void decode_byte(input logic [CODE_W-1:0] code, input logic st);
    logic [CODE_W-1:0] mark;
    int unsigned       reps;
    mark = p_mode ? RLE8_MARK : PCX_MARK;
    new_pixels.delete();
    if (st) begin
      run_armed = 1'b0;
      run_len   = '0;
      emitted   = '0;
      img_full  = 1'b0;
    end
    if (run_armed) begin
      run_armed = 1'b0;
      reps = 32'(run_len);
    end else if ((code & MARK_MASK) == mark) begin
      run_len   = code[COUNT_W-1:0];
      run_armed = 1'b1;
      reps = 0;
    end else begin
      reps = 1;
    end
    for (int i = 0; i < reps; i++) begin
      if (img_full || emitted >= p_size) break;
      emitted = emitted + 1'b1;
      new_pixels.push_back('{code, 1'b0, emitted == p_size});
      if (emitted == p_size) img_full = 1'b1;
    end
    if (new_pixels.size() != 0) new_pixels[$].last = 1'b1;
  endfunction

  task automatic flag_error(input string what);
    errors++;
    if (errors <= 10) $display("%0t: %s", $realtime, what);
  endtask

  // Input transfers are predicted before output transfers are checked, so that the
  // expectation is in place even if a pixel leaves in the cycle its byte arrives.
  always @(posedge clk_i) begin
    pix_t want;
    in_took = rst_ni && code_if.valid && code_if.ready;
    if (in_took) begin
      decode_byte(code_if.code_byte, code_if.start_image);
      if (row_typed) begin
        new_pixels.delete();
        for (int i = 0; i < row_n; i++) new_pixels.push_back('{code_if.code_byte, 1'b0, 1'b0});
        if (row_n > 0) begin
          new_pixels[$].last = 1'b1;
          new_pixels[$].done = row_dn;
        end
      end
      foreach (new_pixels[i]) due_pixels.push_back(new_pixels[i]);
      bytes_in++;
    end
    if (rst_ni && pix_if.valid && pix_if.ready) begin
      pixels_out++;
      if (pix_if.image_done) images_done++;
      if (due_pixels.size() == 0) begin
        flag_error($sformatf("unexpected pixel px=%02h last=%0b done=%0b",
                             pix_if.pixel_byte, pix_if.last_of_item, pix_if.image_done));
      end else begin
        want = due_pixels.pop_front();
        if (want.px !== pix_if.pixel_byte || want.last !== pix_if.last_of_item ||
            want.done !== pix_if.image_done)
          flag_error($sformatf({"pixel %0d: expected px=%02h last=%0b done=%0b, ",
                                "got px=%02h last=%0b done=%0b"},
                               pixels_out, want.px, want.last, want.done, pix_if.pixel_byte,
                               pix_if.last_of_item, pix_if.image_done));
      end
    end
    if (in_took || (pix_if.valid && pix_if.ready)) stall_cycles = 0;
    else stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Timeout: no transfer for %0d cycles, %0d pixels outstanding",
               STALL_LIMIT, due_pixels.size());
      $display("TB_ERROR");
      $finish;
    end
  end

  // Pixel receiver, with one long hold-off on request.
  initial begin
    pix_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_left > 0) begin
        pix_if.ready <= 1'b0;
        hold_left--;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES - 1;
        pix_if.ready <= 1'b0;
      end else begin
        pix_if.ready <= steady || ($urandom_range(99) >= 36);
      end
    end
  end

  task automatic put_byte(input logic [CODE_W-1:0] code, input logic st, input int n,
                          input logic dn);
    row_typed = (n >= 0);
    row_n     = n;
    row_dn    = dn;
    while (!steady && $urandom_range(99) < 36) begin
      code_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    code_if.valid       <= 1'b1;
    code_if.code_byte   <= code;
    code_if.start_image <= st;
    @(negedge clk_i);
    while (!in_took) @(negedge clk_i);
  endtask

  // Waits until every expected pixel has arrived and any silent run has finished.
  task automatic settle();
    code_if.valid <= 1'b0;
    while (due_pixels.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    settle();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_RUN_MODE) p_mode = data[0];
    else p_size = data[SIZE_BITS-1:0];
    reg_writes++;
  endtask

  initial begin
    row_t                  plan [PLAN_LEN];
    logic [CODE_W-1:0]     mark;
    logic [CODE_W-1:0]     lit;
    logic [COUNT_W-1:0]    cnt;
    logic [CFG_DATA_W-1:0] sz;
    logic                  st;
    int unsigned           pick;
    int unsigned           sent;

    plan = '{
      '{ROW_SIZE, 24'd8,     1'b0, 0,  1'b0},
      '{ROW_MODE, MODE_PCX,  1'b0, 0,  1'b0},
      '{ROW_BYTE, 24'h00,    1'b1, 1,  1'b0},
      '{ROW_BYTE, 24'h3F,    1'b0, 1,  1'b0},
      '{ROW_BYTE, 24'h7F,    1'b0, 1,  1'b0},
      '{ROW_BYTE, 24'hC0,    1'b0, 0,  1'b0},
      '{ROW_BYTE, 24'hAA,    1'b0, 0,  1'b0},
      '{ROW_BYTE, 24'hC3,    1'b0, 0,  1'b0},
      '{ROW_BYTE, 24'hFF,    1'b0, -1, 1'b0},
      '{ROW_BYTE, 24'hC5,    1'b0, 0,  1'b0},
      '{ROW_BYTE, 24'h11,    1'b0, -1, 1'b0},
      '{ROW_BYTE, 24'h22,    1'b0, 0,  1'b0},
      '{ROW_SIZE, SIZE_MAX,  1'b0, 0,  1'b0},
      '{ROW_MODE, MODE_RLE8, 1'b0, 0,  1'b0},
      '{ROW_BYTE, 24'hC1,    1'b1, 1,  1'b0},
      '{ROW_BYTE, 24'h7F,    1'b0, 0,  1'b0},
      '{ROW_BYTE, 24'h80,    1'b0, -1, 1'b0},
      '{ROW_BYTE, 24'h41,    1'b0, 0,  1'b0},
      '{ROW_BYTE, 24'h41,    1'b1, 0,  1'b0},
      '{ROW_BYTE, 24'hEE,    1'b0, 1,  1'b0},
      '{ROW_BYTE, 24'h42,    1'b0, 0,  1'b0},
      '{ROW_MODE, MODE_PCX,  1'b0, 0,  1'b0},
      '{ROW_BYTE, 24'h43,    1'b0, -1, 1'b0},
      '{ROW_SIZE, 24'd0,     1'b0, 0,  1'b0},
      '{ROW_BYTE, 24'h01,    1'b1, 0,  1'b0},
      '{ROW_SIZE, 24'd3,     1'b0, 0,  1'b0},
      '{ROW_BYTE, 24'h10,    1'b1, 1,  1'b0},
      '{ROW_BYTE, 24'h20,    1'b0, 1,  1'b0},
      '{ROW_SIZE, 24'd1,     1'b0, 0,  1'b0},
      '{ROW_BYTE, 24'h30,    1'b0, 0,  1'b0},
      '{ROW_BYTE, 24'h80,    1'b1, 1,  1'b1}
    };

    rst_ni              = 1'b0;
    cfg_we_i            = 1'b0;
    cfg_idx_i           = '0;
    cfg_data_i          = '0;
    code_if.valid       = 1'b0;
    code_if.code_byte   = '0;
    code_if.start_image = 1'b0;
    p_mode    = 1'b0;
    p_size    = '0;
    run_armed = 1'b0;
    run_len   = '0;
    emitted   = '0;
    img_full  = 1'b0;
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (plan[i]) begin
      case (plan[i].kind)
        ROW_BYTE: put_byte(plan[i].val[CODE_W-1:0], plan[i].start, plan[i].n, plan[i].dn);
        ROW_MODE: write_reg(REG_RUN_MODE, plan[i].val);
        default:  write_reg(REG_IMAGE_SIZE, plan[i].val);
      endcase
    end

    // Random images: mostly well-formed markers, run values and literals, with some noise.
    for (int ph = 0; ph < PHASES; ph++) begin
      steady = (ph == 0);
      write_reg(REG_RUN_MODE, $urandom_range(1) ? MODE_RLE8 : MODE_PCX);
      pick = $urandom_range(9);
      if (pick < 2) sz = SIZE_MAX;
      else if (pick < 5) sz = CFG_DATA_W'($urandom_range(40, 1));
      else sz = CFG_DATA_W'($urandom_range(400, 41));
      write_reg(REG_IMAGE_SIZE, sz);
      mark = p_mode ? RLE8_MARK : PCX_MARK;
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        st = (sent == 0) || ($urandom_range(99) < 4);
        if (ph == 2 && sent == 3) hold_req = 1'b1;
        if (ph == 3 && sent == 20) settle();
        pick = $urandom_range(99);
        if (pick < 12) begin
          put_byte(8'($urandom), st, -1, 1'b0);
          sent++;
        end else if (pick < 50) begin
          cnt = ($urandom_range(3) == 0) ? 6'($urandom_range(63)) : 6'($urandom_range(8));
          put_byte({mark[7:6], cnt}, st, -1, 1'b0);
          put_byte(8'($urandom), 1'b0, -1, 1'b0);
          sent += 2;
        end else begin
          lit = 8'($urandom);
          if ((lit & MARK_MASK) == mark) lit[6] = ~lit[6];
          put_byte(lit, st, -1, 1'b0);
          sent++;
        end
      end
    end
    steady = 1'b0;

    settle();
    if (due_pixels.size() != 0)
      flag_error($sformatf("%0d pixels never arrived", due_pixels.size()));
    $display("Decoded %0d code bytes into %0d pixels in both marker modes, %0d images filled,",
             bytes_in, pixels_out, images_done);
    $display("%0d register writes, receiver hold-off and random stalls; %0d mismatches.",
             reg_writes, errors);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/dmrle_pkg.sv
hw/rtl/dmrle_in_if.sv
hw/rtl/dmrle_out_if.sv
hw/rtl/dmrle_ctrl.sv
hw/rtl/dmrle_dp.sv
hw/rtl/dual_mode_byte_rle_decoder.sv
verif/tb.sv
